### src/varint_field_decoder_assert.svh
// assertion macros for the varint field decoder
// used by the rtl file that checks its own logic; expects clk_i and rst_ni in scope
`ifndef VARINT_FIELD_DECODER_ASSERT_SVH
`define VARINT_FIELD_DECODER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define VFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define VFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/vfd_pkg.sv
// types, constants and helpers of the varint field decoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package vfd_pkg;

  localparam int unsigned ContBit    = 7;
  localparam int unsigned VarintBits = 7;
  localparam logic [6:0]  VarintMask = 7'h7F;

  // width codes
  localparam logic [1:0] WidthB1 = 2'd0;
  localparam logic [1:0] WidthB2 = 2'd1;
  localparam logic [1:0] WidthB4 = 2'd2;
  localparam logic [1:0] WidthB8 = 2'd3;

  // one input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] width_code;
    logic       fixed_mode;
  } vfd_in_t;

  // one result item
  typedef struct packed {
    logic [63:0] value;
    logic [3:0]  bytes_used;
  } vfd_out_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] byte_idx;
    logic [1:0] width_code;
    logic       fixed_mode;
    logic       last;
  } vfd_op_t;

  // number of destination bytes for a width code
  function automatic logic [3:0] width_bytes(input logic [1:0] code);
    logic [3:0] n;
    case (code)
      WidthB1: n = 4'd1;
      WidthB2: n = 4'd2;
      WidthB4: n = 4'd4;
      WidthB8: n = 4'd8;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

  // value mask for a width code
  function automatic logic [63:0] width_mask(input logic [1:0] code);
    logic [63:0] m;
    case (code)
      WidthB1: m = 64'h0000_0000_0000_00FF;
      WidthB2: m = 64'h0000_0000_0000_FFFF;
      WidthB4: m = 64'h0000_0000_FFFF_FFFF;
      WidthB8: m = 64'hFFFF_FFFF_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

### src/vfd_front.sv
// front end: accepts stream bytes, tracks field boundaries, classifies each byte
// depends on vfd_pkg
`timescale 1ns / 1ps

module vfd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  vfd_pkg::vfd_in_t in_item_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output vfd_pkg::vfd_op_t q_entry_o
);
  import vfd_pkg::*;

  logic       in_field_q, in_field_d;
  logic [3:0] idx_q, idx_d;
  logic [1:0] width_q, width_d;
  logic       fixed_q, fixed_d;

  logic       accept;
  logic [1:0] cur_width;
  logic       cur_fixed;
  logic [3:0] nbytes;
  logic [3:0] idx_next;
  logic       last;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  // width and mode come from the item on the first byte of a field
  assign cur_width = in_field_q ? width_q : in_item_i.width_code;
  assign cur_fixed = in_field_q ? fixed_q : in_item_i.fixed_mode;
  assign nbytes    = width_bytes(cur_width);
  assign idx_next  = idx_q + 4'd1;

  // field end: full width in fixed mode, clear top bit or width+1 bytes in varint mode
  always_comb begin
    if (cur_fixed) begin
      last = (idx_next >= nbytes);
    end else begin
      last = !in_item_i.data_byte[ContBit] || (idx_q >= nbytes);
    end
  end

  assign q_entry_o = '{data_byte:  in_item_i.data_byte,
                       byte_idx:   idx_q,
                       width_code: cur_width,
                       fixed_mode: cur_fixed,
                       last:       last};

  // field tracking state
  always_comb begin
    in_field_d = in_field_q;
    idx_d      = idx_q;
    width_d    = width_q;
    fixed_d    = fixed_q;
    if (accept) begin
      width_d = cur_width;
      fixed_d = cur_fixed;
      if (last) begin
        in_field_d = 1'b0;
        idx_d      = 4'd0;
      end else begin
        in_field_d = 1'b1;
        idx_d      = idx_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_field_q <= 1'b0;
      idx_q      <= 4'd0;
      width_q    <= WidthB1;
      fixed_q    <= 1'b0;
    end else begin
      in_field_q <= in_field_d;
      idx_q      <= idx_d;
      width_q    <= width_d;
      fixed_q    <= fixed_d;
    end
  end

endmodule

### src/vfd_fifo.sv
// short queue of classified bytes between front and back
// depends on vfd_pkg
`timescale 1ns / 1ps

module vfd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vfd_pkg::vfd_op_t entry_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output vfd_pkg::vfd_op_t entry_o
);
  import vfd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  vfd_op_t mem_q [Depth];

  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

endmodule

### src/vfd_back.sv
// back end: shifts each byte into the accumulator and registers finished fields
// depends on vfd_pkg and the assertion macro header
`timescale 1ns / 1ps

module vfd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  vfd_pkg::vfd_op_t  q_entry_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output vfd_pkg::vfd_out_t out_item_o
);
  import vfd_pkg::*;
  `include "varint_field_decoder_assert.svh"

  logic [63:0] acc_q, acc_d;
  logic        out_valid_q, out_valid_d;
  vfd_out_t    out_q;

  logic [63:0] fixed_part;
  logic [63:0] varint_part;
  logic [63:0] acc_new;
  logic [6:0]  shift7;
  logic        pop_last;

  // a closing byte waits for the output register, other bytes go straight in
  assign q_pop_o  = q_valid_i && (!q_entry_i.last || !out_valid_q || !out_stall_i);
  assign pop_last = q_pop_o && q_entry_i.last;

  // bit position 7 * index for varint payload bits
  assign shift7 = ({3'b000, q_entry_i.byte_idx} << 3) - {3'b000, q_entry_i.byte_idx};

  // byte placement for both modes
  always_comb begin
    fixed_part  = '0;
    varint_part = {57'd0, q_entry_i.data_byte[VarintBits-1:0] & VarintMask} << shift7;
    if (!q_entry_i.byte_idx[3]) begin
      fixed_part = {56'd0, q_entry_i.data_byte} << {q_entry_i.byte_idx[2:0], 3'b000};
    end
    acc_new = acc_q | (q_entry_i.fixed_mode ? fixed_part : varint_part);
  end

  // accumulator and output valid
  always_comb begin
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (q_pop_o) begin
      acc_d = q_entry_i.last ? '0 : acc_new;
    end
    if (pop_last) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_last) begin
      out_q.value      <= acc_new & width_mask(q_entry_i.width_code);
      out_q.bytes_used <= q_entry_i.byte_idx + 4'd1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks
  `VFD_ASSERT_IMP(no_overwrite_a, out_valid_q && out_stall_i, !pop_last,
                  "field result overwrote a stalled result")
  `VFD_ASSERT_NXT(acc_clear_a, pop_last, acc_q == '0,
                  "accumulator not cleared after field end")
  `VFD_ASSERT_IMP(count_range_a, out_valid_q,
                  (out_q.bytes_used >= 4'd1) && (out_q.bytes_used <= 4'd9),
                  "bytes used out of range")

endmodule

### src/varint_field_decoder.sv
// result: registered; a field's last byte passes the queue, then the output register
//   in the back end, and an output stall can hold a closing byte in the queue
// throughput: one byte per cycle while in_stall_o is low (it is high while the queue is
//   full), one result per field; the back end shift-ors bytes into a 64-bit accumulator
// reset: asynchronous active low, clears field tracking, queue and output valid
// depends on vfd_pkg, vfd_front, vfd_fifo, vfd_back
`timescale 1ns / 1ps

module varint_field_decoder #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  vfd_pkg::vfd_in_t  in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output vfd_pkg::vfd_out_t out_item_o
);
  import vfd_pkg::*;

  logic    q_push;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  vfd_op_t q_wr_entry;
  vfd_op_t q_rd_entry;

  // byte classification
  vfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_wr_entry)
  );

  // decoupling queue
  vfd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (q_rd_entry)
  );

  // accumulation and result register
  vfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_rd_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
